>>> rtl/rsa_pkg.sv
package rsa_pkg;

    localparam int StackDepth = 256;
    localparam int PtrW = $clog2(StackDepth);
    localparam int WordW = 32;
    localparam int CmdW = 5;

    typedef enum logic [CmdW-1:0] {
        CMD_PUSH = 5'd0, CMD_ADD = 5'd1, CMD_SUB = 5'd2, CMD_MUL = 5'd3,
        CMD_DIV = 5'd4, CMD_MOD = 5'd5, CMD_INV = 5'd6, CMD_SHR = 5'd7,
        CMD_SHL = 5'd8, CMD_AND = 5'd9, CMD_OR = 5'd10, CMD_XOR = 5'd11,
        CMD_GT = 5'd12, CMD_LT = 5'd13, CMD_EQ = 5'd14, CMD_DROP = 5'd15,
        CMD_DUP = 5'd16, CMD_SWAP = 5'd17, CMD_PICK = 5'd18, CMD_PUT = 5'd19,
        CMD_POPW = 5'd20, CMD_POPB = 5'd21, CMD_POPS = 5'd22, CMD_POPBS = 5'd23,
        CMD_CLR = 5'd24
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_WR2, ST_PICK, ST_PUT, ST_DIV, ST_CLR, ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic              want_mod;
        logic [WordW-1:0]  num;
        logic [WordW-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WordW-1:0]  res;
    } t_div_rsp;

endpackage

>>> rtl/rpn_stack_alu.sv
// rpn_stack_alu: reverse-Polish evaluator over a 256-entry stack RAM.
// Slave channel: s_axis_tdata = {push_value[36:5], command[4:0]}, padded to 40 bits.
// Master channel: m_axis_tdata = {sample[63:32], read_value[31:0]}.
// One request is processed at a time. The stack lives in a single-port
// synchronous RAM with a registered read, so each stack read has its own state.
// States per request, from ST_IDLE back to ST_IDLE: push: none; drop,
//   invert: ST_RD1; dup: ST_RD1, ST_WR2; pick, put: ST_RD1, then ST_PICK
//   or ST_PUT; pops: ST_RD1, then ST_OUT until m_axis_tready; swap: ST_RD1,
//   ST_RD2, ST_WR2; add, sub, shifts, logic ops, compares, mul: ST_RD1,
//   ST_RD2, ST_EXEC; div/mod: ST_RD1, ST_RD2, ST_DIV on the shift-subtract
//   divider, ending early on a zero divisor; clear: ST_CLR over all 256 entries.
// Only popword, popbyte, popsample and popbytesample emit a result; it is
// held in an output register until m_axis_tready, and the next request is
// not taken before that. A stalled receiver thus stalls the slave side.
// Reset: synchronous, active low. It starts a clearing pass over all 256
// RAM entries during which s_axis_tready stays low; the pointer returns to 0.
module rpn_stack_alu
    import rsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // command[4:0], push_value[36:5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // read_value[31:0], sample[63:32]
);

    logic [WordW-1:0] r_mem [StackDepth];
    logic [WordW-1:0] r_rd;
    logic [PtrW-1:0]  w_addr;
    logic             w_we;
    logic [WordW-1:0] w_wd;

    t_state           r_st, n_st;
    t_cmd             r_cmd, n_cmd;
    logic [WordW-1:0] r_top, n_top, r_sec, n_sec, r_v, n_v;
    logic [PtrW-1:0]  r_sp, n_sp, r_clr, n_clr;
    logic [WordW-1:0] r_ov, n_ov, r_os, n_os;
    logic             r_mul, n_mul;
    logic [63:0]      w_prod;
    t_div_req         w_dreq;
    t_div_rsp         w_drsp;

    rsa_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wd;
        r_rd <= r_mem[w_addr];
    end

    assign w_prod = r_sec * r_top;

    always_comb begin
        n_st = r_st; n_cmd = r_cmd; n_top = r_top; n_sec = r_sec;
        n_v = r_v; n_sp = r_sp; n_clr = r_clr; n_ov = r_ov; n_os = r_os; n_mul = 1'b0;
        w_addr = r_sp; w_we = 1'b0; w_wd = '0;
        w_dreq = '{start: 1'b0, want_mod: (r_cmd == CMD_MOD), num: r_sec, den: r_top};
        s_axis_tready = 1'b0;
        case (r_st)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_cmd = t_cmd'(s_axis_tdata[4:0]);
                    case (t_cmd'(s_axis_tdata[4:0]))
                        CMD_PUSH: begin
                            w_addr = r_sp; w_we = 1'b1; w_wd = s_axis_tdata[36:5];
                            n_sp = r_sp + 1'b1;
                        end
                        CMD_CLR: begin
                            n_clr = '0; n_st = ST_CLR;
                        end
                        default: begin
                            if (s_axis_tdata[4:0] <= CMD_POPBS) begin
                                w_addr = r_sp - 1'b1; n_sp = r_sp - 1'b1; n_st = ST_RD1;
                            end
                        end
                    endcase
                end
            end
            ST_RD1: begin
                n_top = r_rd;
                case (r_cmd) inside
                    [CMD_ADD:CMD_MOD], [CMD_SHR:CMD_EQ], CMD_SWAP: begin
                        w_addr = r_sp - 1'b1; n_sp = r_sp - 1'b1; n_st = ST_RD2;
                    end
                    CMD_INV: begin
                        w_addr = r_sp; w_we = 1'b1; w_wd = ~r_rd;
                        n_sp = r_sp + 1'b1; n_st = ST_IDLE;
                    end
                    CMD_DROP: n_st = ST_IDLE;
                    CMD_DUP: begin
                        n_v = r_rd; n_sp = r_sp + 1'b1; n_st = ST_WR2;
                    end
                    CMD_PICK: begin
                        w_addr = r_sp - r_rd[PtrW-1:0]; n_st = ST_PICK;
                    end
                    CMD_PUT: begin
                        w_addr = r_sp - 1'b1; n_st = ST_PUT;
                    end
                    CMD_POPW: begin
                        n_ov = r_rd; n_os = '0; n_st = ST_OUT;
                    end
                    CMD_POPB: begin
                        n_ov = {24'd0, r_rd[7:0]}; n_os = '0; n_st = ST_OUT;
                    end
                    CMD_POPS: begin
                        n_ov = r_rd; n_os = {~r_rd[31], r_rd[30:0]}; n_st = ST_OUT;
                    end
                    CMD_POPBS: begin
                        n_ov = r_rd; n_os = {r_rd[7:0] - 8'd128, 24'd0}; n_st = ST_OUT;
                    end
                    default: n_st = ST_IDLE;
                endcase
            end
            ST_RD2: begin
                n_sec = r_rd;
                if (r_cmd == CMD_SWAP) begin
                    n_v = r_rd; w_addr = r_sp; w_we = 1'b1; w_wd = r_top;
                    n_sp = r_sp + 1'b1; n_st = ST_WR2;
                end else if (r_cmd == CMD_DIV || r_cmd == CMD_MOD) begin
                    n_st = ST_DIV;
                end else begin
                    n_mul = (r_cmd == CMD_MUL); n_st = ST_EXEC;
                end
            end
            ST_DIV: begin
                w_dreq.start = !r_mul;
                n_mul = 1'b1;
                if (r_mul && w_drsp.done) begin
                    w_addr = r_sp; w_we = 1'b1;
                    if ($signed(r_sec) == 32'sh8000_0000 && r_top == '1)
                        w_wd = (r_cmd == CMD_MOD) ? '0 : r_sec;
                    else w_wd = w_drsp.res;
                    n_sp = r_sp + 1'b1; n_mul = 1'b0; n_st = ST_IDLE;
                end
            end
            ST_EXEC: begin
                if (r_mul) begin
                    n_v = w_prod[31:0];
                end else begin
                    w_addr = r_sp; w_we = 1'b1; n_sp = r_sp + 1'b1; n_st = ST_IDLE;
                    case (r_cmd)
                        CMD_ADD: w_wd = r_sec + r_top;
                        CMD_SUB: w_wd = r_sec - r_top;
                        CMD_MUL: w_wd = r_v;
                        CMD_SHR: w_wd = $signed(r_sec) >>> r_top[4:0];
                        CMD_SHL: w_wd = r_sec << r_top[4:0];
                        CMD_AND: w_wd = r_sec & r_top;
                        CMD_OR:  w_wd = r_sec | r_top;
                        CMD_XOR: w_wd = r_sec ^ r_top;
                        CMD_GT:  w_wd = {WordW{$signed(r_sec) > $signed(r_top)}};
                        CMD_LT:  w_wd = {WordW{$signed(r_sec) < $signed(r_top)}};
                        CMD_EQ:  w_wd = {WordW{r_sec == r_top}};
                        default: w_wd = '0;
                    endcase
                end
            end
            ST_WR2: begin
                w_addr = r_sp; w_we = 1'b1; w_wd = r_v;
                n_sp = r_sp + 1'b1; n_st = ST_IDLE;
            end
            ST_PICK: begin
                w_addr = r_sp; w_we = 1'b1; w_wd = r_rd;
                n_sp = r_sp + 1'b1; n_st = ST_IDLE;
            end
            ST_PUT: begin
                w_addr = r_sp - r_rd[PtrW-1:0] - 1'b1; w_we = 1'b1; w_wd = r_top;
                n_st = ST_IDLE;
            end
            ST_CLR: begin
                w_addr = r_clr; w_we = 1'b1; w_wd = '0;
                n_clr = r_clr + 1'b1; n_sp = '0;
                if (r_clr == PtrW'(StackDepth - 1)) n_st = ST_IDLE;
            end
            ST_OUT: begin
                if (m_axis_tready) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_CLR;
            r_clr <= '0;
            r_sp  <= '0;
            r_mul <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_clr <= n_clr;
            r_sp  <= n_sp;
            r_mul <= n_mul;
        end
        r_cmd <= n_cmd; r_top <= n_top; r_sec <= n_sec;
        r_v <= n_v; r_ov <= n_ov; r_os <= n_os;
    end

    assign m_axis_tvalid = (r_st == ST_OUT);
    assign m_axis_tdata  = {r_os, r_ov};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_st == ST_IDLE) else $error("ready outside idle");
    a_clr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_CLR |-> w_we && w_wd == '0) else $error("clear not writing zero");

endmodule

>>> rtl/rsa_div.sv
module rsa_div
    import rsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic [5:0]        r_cnt, n_cnt;
    logic [WordW-1:0]  r_q, n_q, r_rem, n_rem, r_d, n_d;
    logic              r_nneg, n_nneg, r_qneg, n_qneg, r_mod, n_mod, r_done, n_done;
    logic [WordW-1:0]  r_res, n_res;
    logic [WordW:0]    w_trial;
    logic [WordW-1:0]  w_rs;

    always_comb begin
        n_busy = r_busy; n_cnt = r_cnt; n_q = r_q; n_rem = r_rem; n_d = r_d;
        n_nneg = r_nneg; n_qneg = r_qneg; n_mod = r_mod; n_done = 1'b0; n_res = r_res;
        w_rs = {r_rem[WordW-2:0], r_q[WordW-1]};
        w_trial = {1'b0, w_rs} - {1'b0, r_d};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_mod  = i_req.want_mod;
            n_nneg = i_req.num[WordW-1];
            n_qneg = i_req.num[WordW-1] ^ i_req.den[WordW-1];
            n_q    = i_req.num[WordW-1] ? -i_req.num : i_req.num;
            n_d    = i_req.den[WordW-1] ? -i_req.den : i_req.den;
            n_rem  = '0;
        end else if (r_busy) begin
            if (r_d == '0) begin
                n_busy = 1'b0; n_done = 1'b1; n_res = '0;
            end else if (r_cnt == 6'd32) begin
                n_busy = 1'b0; n_done = 1'b1;
                if (r_mod) n_res = r_nneg ? -r_rem : r_rem;
                else       n_res = r_qneg ? -r_q : r_q;
            end else begin
                n_cnt = r_cnt + 6'd1;
                if (!w_trial[WordW]) begin
                    n_rem = w_trial[WordW-1:0];
                    n_q   = {r_q[WordW-2:0], 1'b1};
                end else begin
                    n_rem = w_rs;
                    n_q   = {r_q[WordW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt; r_q <= n_q; r_rem <= n_rem; r_d <= n_d; r_nneg <= n_nneg;
        r_qneg <= n_qneg; r_mod <= n_mod; r_res <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("div done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("div not busy after start");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 6'd32) else $error("div count overrun");

endmodule
